// ===== hdl/jsr_pkg.sv =====
// Shared types, codes and constants of the joypad serial command receiver.
package jsr_pkg;

    localparam int JSR_PACKET_BYTES = 16;
    localparam int JSR_MAX_PACKETS  = 7;

    localparam int PN_W  = 3;
    localparam int CMD_W = 5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CMD_W-1:0] CMD_PLAYERS = 5'h11;
    localparam logic [CMD_W-1:0] CMD_MASK    = 5'h17;

    localparam logic [7:0] ID_BYTE = 8'hFE;

    typedef struct packed {
        logic             read_override;
        logic [7:0]       read_data;
        logic             command_done;
        logic [CMD_W-1:0] command_code;
        logic [1:0]       player_mode;
        logic [1:0]       screen_mask;
    } jsr_result_t;

endpackage

// ===== hdl/jsr_store.sv =====
// Packet byte store with two registered read ports fixed on the header bytes.
module jsr_store #(
    parameter int DEPTH = 112,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rd0,
    output logic [7:0]    rd1
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rd0_reg;
    logic [7:0] rd1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Write-first reads, so a byte being written is seen by the next item.
    always_ff @(posedge clk)
    begin
        rd0_reg <= (we && waddr == AW'(0)) ? wdata : mem[AW'(0)];
        rd1_reg <= (we && waddr == AW'(1)) ? wdata : mem[AW'(1)];
    end

    assign rd0 = rd0_reg;
    assign rd1 = rd1_reg;

endmodule

// ===== hdl/jsr_rx.sv =====
// Bit receiver: packet framing, byte assembly, header decode and settings.
module jsr_rx #(
    parameter int PACKET_BYTES = 16,
    parameter int MAX_PACKETS  = 7,
    parameter int AW           = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                operation,
    input  logic [7:0]          value,
    output logic                we,
    output logic [AW-1:0]       waddr,
    output logic [7:0]          wdata,
    input  logic [7:0]          rd0,
    input  logic [7:0]          rd1,
    output jsr_pkg::jsr_result_t result
);
    import jsr_pkg::*;

    localparam int BPW = $clog2(PACKET_BYTES * 8);
    localparam logic [BPW-1:0] LAST_BIT = BPW'(PACKET_BYTES * 8 - 1);
    localparam logic [PN_W-1:0] MAX_PN  = PN_W'(MAX_PACKETS);
    localparam logic [PN_W-1:0] TOP_PN  = PN_W'(MAX_PACKETS - 1);

    typedef enum logic [1:0] {PH_WAIT, PH_DATA, PH_STOP} phase_t;

    phase_t            phase_reg, phase_next;
    logic [BPW-1:0]    bit_pos_reg, bit_pos_next;
    logic [PN_W-1:0]   pn_reg, pn_next;
    logic [PN_W-1:0]   left_reg, left_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [1:0]        players_reg, players_next;
    logic [1:0]        mask_reg, mask_next;
    logic [6:0]        asm_reg, asm_next;

    logic              p15, p14, bitv;
    logic [PN_W-1:0]   len_raw, len_sat, left_cur, left_dec, pn_inc;
    logic [CMD_W-1:0]  cmd_cur;
    logic              done;

    assign p15  = value[5];
    assign p14  = value[4];
    assign bitv = !p15 && p14;

    always_comb
    begin
        len_raw = rd0[2:0];
        if (len_raw == '0)
        begin
            len_sat = PN_W'(1);
        end
        else if (len_raw > MAX_PN)
        begin
            len_sat = MAX_PN;
        end
        else
        begin
            len_sat = len_raw;
        end
        left_cur = (pn_reg == '0) ? len_sat : left_reg;
        cmd_cur  = (pn_reg == '0) ? rd0[7:3] : cmd_reg;
        left_dec = (left_cur != '0) ? left_cur - PN_W'(1) : '0;
        pn_inc   = pn_reg + PN_W'(1);
    end

    always_comb
    begin
        phase_next   = phase_reg;
        bit_pos_next = bit_pos_reg;
        pn_next      = pn_reg;
        left_next    = left_reg;
        cmd_next     = cmd_reg;
        players_next = players_reg;
        mask_next    = mask_reg;
        asm_next     = asm_reg;
        we           = 1'b0;
        waddr        = AW'(32'(pn_reg) * PACKET_BYTES + 32'(bit_pos_reg[BPW-1:3]));
        wdata        = {bitv, asm_reg};
        done         = 1'b0;

        if (operation == OP_WRITE && !(p14 && p15))
        begin
            if (!p14 && !p15)
            begin
                if (phase_reg == PH_WAIT)
                begin
                    if (left_reg == '0)
                    begin
                        pn_next = '0;
                    end
                    bit_pos_next = '0;
                    phase_next   = PH_DATA;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_DATA:
                    begin
                        // Bits gather LSB-first; the whole byte is written on its last bit.
                        asm_next = {bitv, asm_reg[6:1]};
                        we       = (bit_pos_reg[2:0] == 3'd7);
                        if (bit_pos_reg == LAST_BIT)
                        begin
                            phase_next   = PH_STOP;
                            bit_pos_next = '0;
                        end
                        else
                        begin
                            bit_pos_next = bit_pos_reg + BPW'(1);
                        end
                    end
                    PH_STOP:
                    begin
                        if (!bitv)
                        begin
                            cmd_next   = cmd_cur;
                            left_next  = left_dec;
                            phase_next = PH_WAIT;
                            if (left_dec == '0)
                            begin
                                if (cmd_cur == CMD_PLAYERS)
                                begin
                                    players_next = rd1[1:0];
                                end
                                else if (cmd_cur == CMD_MASK)
                                begin
                                    mask_next = rd1[1:0];
                                end
                                pn_next = '0;
                                done    = 1'b1;
                            end
                            else
                            begin
                                pn_next = (pn_inc >= MAX_PN) ? TOP_PN : pn_inc;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        we = we && accept;
    end

    always_comb
    begin
        result               = '0;
        result.player_mode   = players_next;
        result.screen_mask   = mask_next;
        result.command_done  = done;
        result.command_code  = done ? cmd_cur : '0;
        if (operation == OP_READ && players_reg != 2'd0 && p15 && p14)
        begin
            result.read_override = 1'b1;
            result.read_data     = ID_BYTE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            bit_pos_reg <= '0;
            pn_reg      <= '0;
            left_reg    <= '0;
            cmd_reg     <= '0;
            players_reg <= '0;
            mask_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            bit_pos_reg <= bit_pos_next;
            pn_reg      <= pn_next;
            left_reg    <= left_next;
            cmd_reg     <= cmd_next;
            players_reg <= players_next;
            mask_reg    <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            asm_reg <= asm_next;
        end
    end

    a_pn_range: assert property (@(posedge clk) disable iff (!rst_n)
        pn_reg <= TOP_PN)
        else $error("packet number beyond the store");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done) |=> (phase_reg == PH_WAIT && left_reg == '0 && pn_reg == '0))
        else $error("command completion did not return to waiting");

    a_read_still: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_READ) |=>
            ($stable(phase_reg) && $stable(bit_pos_reg) && $stable(players_reg)))
        else $error("a read changed receiver state");

    a_write_data: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (phase_reg == PH_DATA && !result.read_override))
        else $error("store written outside data phase");

endmodule

// ===== hdl/jsr_out.sv =====
// Output register between the receiver and the result stream.
module jsr_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  jsr_pkg::jsr_result_t in_result,
    output logic                 out_valid,
    input  logic                 out_ready,
    output jsr_pkg::jsr_result_t out_result
);
    import jsr_pkg::*;

    logic        valid_reg;
    jsr_result_t result_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            result_reg <= in_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ===== hdl/joypad_serial_command_receiver.sv =====
// Top level of the joypad serial command receiver.
// Each joypad register access is one item and the block takes one item per clock cycle;
// its result is captured in an output register, which keeps taking items while
// the result stream is ready or the register is empty. Packet bits are gathered LSB-first and
// each byte is written whole into a store of MAX_PACKETS * PACKET_BYTES bytes on its last bit,
// so no clearing pass follows reset. The store's two read ports stay on the header and
// parameter bytes of the first packet with write-first bypass.
module joypad_serial_command_receiver #(
    parameter int PACKET_BYTES = jsr_pkg::JSR_PACKET_BYTES,
    parameter int MAX_PACKETS  = jsr_pkg::JSR_MAX_PACKETS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // value[7:0]
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_data[7:0], command_code[12:8], player_mode[14:13],
                                   // screen_mask[16:15], zero fill[23:17]
    output logic [1:0]  m_tuser    // read_override[0], command_done[1]
);
    import jsr_pkg::*;

    localparam int DEPTH = MAX_PACKETS * PACKET_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic          accept;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [7:0]    rd0, rd1;
    jsr_result_t   rx_result, out_result;

    assign accept = s_tvalid && s_tready;

    jsr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .rd0   (rd0),
        .rd1   (rd1)
    );

    jsr_rx #(
        .PACKET_BYTES (PACKET_BYTES),
        .MAX_PACKETS  (MAX_PACKETS),
        .AW           (AW)
    ) u_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (s_tuser[0]),
        .value     (s_tdata),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .rd0       (rd0),
        .rd1       (rd1),
        .result    (rx_result)
    );

    jsr_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_result  (rx_result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {7'd0, out_result.screen_mask, out_result.player_mode,
                      out_result.command_code, out_result.read_data};
    assign m_tuser = {out_result.command_done, out_result.read_override};

endmodule
